[rtl/core/pcsw_pkg.sv]
`timescale 1ns / 1ps
// Shared types, widths and codes of the PIN check block.
package pcsw_pkg;

  localparam int unsigned DEF_CLIENTS      = 16;
  localparam int unsigned DEF_MAX_ATTEMPTS = 8;

  localparam int unsigned PIN_W      = 14;
  localparam int unsigned LIMIT_W    = 4;
  localparam int unsigned WIN_W      = 16;
  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [PIN_W-1:0]   PIN_RESET    = PIN_W'(0);
  localparam logic [LIMIT_W-1:0] LIMIT_RESET  = LIMIT_W'(5);
  localparam logic [WIN_W-1:0]   WINDOW_RESET = WIN_W'(60);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PIN_CODE       = 2'd0,
    CFG_ATTEMPT_LIMIT  = 2'd1,
    CFG_WINDOW_SECONDS = 2'd2
  } cfg_reg_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_BAD     = 2'd1,
    ST_LIMITED = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

  typedef enum logic {
    FUNC_VERIFY = 1'b0,
    FUNC_CLEAR  = 1'b1
  } func_e;

  typedef struct packed {
    logic [PIN_W-1:0]   pin_code;
    logic [LIMIT_W-1:0] attempt_limit;
    logic [WIN_W-1:0]   window_seconds;
  } cfg_t;

  typedef struct packed {
    logic    valid;
    status_e status;
  } res_t;

endpackage

[rtl/core/pcsw_if.sv]
`timescale 1ns / 1ps
// Valid/ready channels: request word in, status word out.
interface pcsw_req_if import pcsw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              func;
  logic [ADDR_W-1:0] client_addr;
  logic [PIN_W-1:0]  submitted_code;
  logic [TIME_W-1:0] now_seconds;

  modport source (output valid, func, client_addr, submitted_code, now_seconds,
                  input ready);
  modport sink   (input valid, func, client_addr, submitted_code, now_seconds,
                  output ready);
endinterface

interface pcsw_rsp_if import pcsw_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;

  modport source (output valid, status, input ready);
  modport sink   (input valid, status, output ready);
endinterface

[rtl/core/pin_check_with_sliding_window_limit.sv]
`timescale 1ns / 1ps
// PIN check with a per-client sliding-window failure limit: top level.
//
// Usage:
//   req_i  : request word (func, client_addr, submitted_code, now_seconds),
//            taken when valid and ready are both high. func clear empties
//            the whole client table; verify checks a PIN for one client.
//   rsp_o  : one status word per request (ok, bad pin, rate limited,
//            table full), held in an output register until taken.
//   cfg_*  : register write port (pin code, attempt limit, window length),
//            written by the user only while the block is idle; not enforced.
// Flow, accepting edge to rsp_o.valid: a clear word goes from idle straight
//   to the done state. A verify word runs a slot search (one slot read per
//   cycle through the address memory), then the decision state, then the
//   done state, from which the status moves into the output register. A
//   client with a slot adds fetching the ring state and checking the oldest
//   stamp, plus a read and a check for each expired timestamp dropped
//   through the shared age comparator. The next word can be taken in the
//   cycle after the status leaves the sequencer.
// The block is not ready while a word is in work; it takes the next word
// while the previous status still waits in the output register, and a
// stalled receiver holds the sequencer after the next decision.
// Reset clears the client table valid bits and sets the registers to
// pin 0, limit 5, window 60 s; no clearing pass is needed.
module pin_check_with_sliding_window_limit import pcsw_pkg::*; #(
  parameter int unsigned CLIENTS      = DEF_CLIENTS,
  parameter int unsigned MAX_ATTEMPTS = DEF_MAX_ATTEMPTS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  pcsw_req_if.sink              req_i,
  pcsw_rsp_if.source            rsp_o
);

  cfg_t    cfg_q;
  res_t    core_res;
  logic    res_ready;
  logic    out_valid_q;
  status_e out_status_q;

  // config registers; unknown index is dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pin_code       <= PIN_RESET;
      cfg_q.attempt_limit  <= LIMIT_RESET;
      cfg_q.window_seconds <= WINDOW_RESET;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CFG_PIN_CODE:       cfg_q.pin_code       <= cfg_wdata_i[PIN_W-1:0];
        CFG_ATTEMPT_LIMIT:  cfg_q.attempt_limit  <= cfg_wdata_i[LIMIT_W-1:0];
        CFG_WINDOW_SECONDS: cfg_q.window_seconds <= cfg_wdata_i[WIN_W-1:0];
        default: ;
      endcase
    end
  end

  pcsw_core #(
    .CLIENTS      (CLIENTS),
    .MAX_ATTEMPTS (MAX_ATTEMPTS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req         (req_i),
    .cfg_i       (cfg_q),
    .res_o       (core_res),
    .res_ready_i (res_ready)
  );

  // output register: free when empty or being drained this cycle
  assign res_ready = !out_valid_q || rsp_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      out_status_q <= ST_OK;
    end else if (res_ready) begin
      out_valid_q <= core_res.valid;
      if (core_res.valid) begin
        out_status_q <= core_res.status;
      end
    end
  end

  assign rsp_o.valid  = out_valid_q;
  assign rsp_o.status = out_status_q;

  // an accepted word always puts the sequencer to work
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid && req_i.ready |=> !req_i.ready)
    else $error("ready stayed high after an accepted word");

  // a pending status from the sequencer waits until the output register is free
  a_res_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    core_res.valid && !res_ready |=> core_res.valid && $stable(core_res.status))
    else $error("sequencer status lost while output register full");

  // sequencer never takes a word while it holds a status
  a_no_accept_with_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    core_res.valid |-> !req_i.ready)
    else $error("ready high while a status is pending");

endmodule

[rtl/core/pcsw_expiry_cmp.sv]
`timescale 1ns / 1ps
// Shared age compare: is a failure timestamp at least one window old.
module pcsw_expiry_cmp import pcsw_pkg::*; (
  input  logic [TIME_W-1:0] now_i,
  input  logic [TIME_W-1:0] stamp_i,
  input  logic [WIN_W-1:0]  window_i,
  output logic              expired_o
);

  logic [TIME_W-1:0] age;

  assign age = now_i - stamp_i;
  // future stamps never expire
  assign expired_o = (now_i >= stamp_i) && (age >= TIME_W'(window_i));

endmodule

[rtl/core/pcsw_core.sv]
`timescale 1ns / 1ps
// Sequencer: slot search, ring pruning and failure recording.
module pcsw_core import pcsw_pkg::*; #(
  parameter int unsigned CLIENTS      = DEF_CLIENTS,
  parameter int unsigned MAX_ATTEMPTS = DEF_MAX_ATTEMPTS
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  pcsw_req_if.sink req,
  input  cfg_t  cfg_i,
  output res_t  res_o,
  input  logic  res_ready_i
);

  localparam int unsigned IW     = (CLIENTS > 1) ? $clog2(CLIENTS) : 1;
  localparam int unsigned SW     = $clog2(CLIENTS + 1);
  localparam int unsigned HW     = (MAX_ATTEMPTS > 1) ? $clog2(MAX_ATTEMPTS) : 1;
  localparam int unsigned CW     = $clog2(MAX_ATTEMPTS + 1);
  localparam int unsigned MW     = CW + HW;
  localparam int unsigned FDEPTH = CLIENTS * MAX_ATTEMPTS;
  localparam int unsigned FAW    = (FDEPTH > 1) ? $clog2(FDEPTH) : 1;
  localparam int unsigned LW     = (CW > LIMIT_W) ? CW : LIMIT_W;
  localparam int unsigned PW     = CW + 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_META,
    S_LOAD,
    S_PRUNE_RD,
    S_PRUNE_CHK,
    S_DECIDE,
    S_DONE
  } state_e;

  state_e             state_q;
  logic [SW-1:0]      scan_q;
  logic               cmp_v_q;
  logic [IW-1:0]      cmp_idx_q;
  logic               found_v_q;
  logic [IW-1:0]      found_idx_q;
  logic               free_v_q;
  logic [IW-1:0]      free_idx_q;
  logic [CW-1:0]      cnt_q;
  logic [HW-1:0]      head_q;
  logic [ADDR_W-1:0]  addr_q;
  logic [PIN_W-1:0]   code_q;
  logic [TIME_W-1:0]  now_q;
  status_e            status_q;
  logic [CLIENTS-1:0] valid_q;

  // memories
  logic [ADDR_W-1:0] addr_mem [CLIENTS];
  logic [MW-1:0]     meta_mem [CLIENTS];
  logic [TIME_W-1:0] fail_mem [FDEPTH];
  logic [ADDR_W-1:0] addr_rd_q;
  logic [MW-1:0]     meta_rd_q;
  logic [TIME_W-1:0] fail_rd_q;

  logic          expired;
  logic [IW-1:0] scan_idx;
  logic [FAW-1:0] fail_raddr, fail_waddr;
  logic [HW-1:0] head_inc;

  logic [LW-1:0] lim_ext, max_ext, lim_eff;
  logic          limited, pin_ok, rec_v, addr_we, meta_we, fail_we;
  logic [IW-1:0] rec_idx, meta_widx;
  logic [CW-1:0] rec_cnt, new_cnt;
  logic [HW-1:0] rec_head;
  logic [PW-1:0] pos_sum, pos;
  logic [MW-1:0] meta_wdata;
  status_e       decide_status;

  assign scan_idx = scan_q[IW-1:0];

  pcsw_expiry_cmp u_expiry (
    .now_i     (now_q),
    .stamp_i   (fail_rd_q),
    .window_i  (cfg_i.window_seconds),
    .expired_o (expired)
  );

  assign fail_raddr = FAW'(found_idx_q) * FAW'(MAX_ATTEMPTS) + FAW'(head_q);
  assign head_inc   = (head_q == HW'(MAX_ATTEMPTS - 1)) ? '0 : head_q + 1'b1;

  // effective limit = min(attempt_limit, MAX_ATTEMPTS)
  assign lim_ext = LW'(cfg_i.attempt_limit);
  assign max_ext = LW'(MAX_ATTEMPTS);
  assign lim_eff = (lim_ext < max_ext) ? lim_ext : max_ext;

  assign limited  = found_v_q && (LW'(cnt_q) >= lim_eff);
  assign pin_ok   = (code_q == cfg_i.pin_code);
  assign rec_v    = found_v_q || free_v_q;
  assign rec_idx  = found_v_q ? found_idx_q : free_idx_q;
  assign rec_cnt  = found_v_q ? cnt_q : '0;
  assign rec_head = found_v_q ? head_q : '0;
  assign new_cnt  = rec_cnt + 1'b1;

  // ring position of the new stamp, sum stays below 2*MAX_ATTEMPTS
  assign pos_sum = PW'(rec_head) + PW'(rec_cnt);
  assign pos     = (pos_sum >= PW'(MAX_ATTEMPTS)) ? pos_sum - PW'(MAX_ATTEMPTS) : pos_sum;
  assign fail_waddr = FAW'(rec_idx) * FAW'(MAX_ATTEMPTS) + FAW'(pos[HW-1:0]);

  always_comb begin
    addr_we       = 1'b0;
    meta_we       = 1'b0;
    fail_we       = 1'b0;
    meta_widx     = rec_idx;
    meta_wdata    = {new_cnt, rec_head};
    decide_status = ST_OK;
    if (limited) begin
      decide_status = ST_LIMITED;
      meta_we       = (state_q == S_DECIDE);
      meta_widx     = found_idx_q;
      meta_wdata    = {cnt_q, head_q};
    end else if (pin_ok) begin
      decide_status = ST_OK;
    end else if (!rec_v) begin
      decide_status = ST_FULL;
    end else begin
      decide_status = (LW'(new_cnt) >= lim_eff) ? ST_LIMITED : ST_BAD;
      meta_we       = (state_q == S_DECIDE);
      fail_we       = (state_q == S_DECIDE);
      addr_we       = (state_q == S_DECIDE) && !found_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (addr_we) begin
      addr_mem[free_idx_q] <= addr_q;
    end
    addr_rd_q <= addr_mem[scan_idx];
  end

  always_ff @(posedge clk_i) begin
    if (meta_we) begin
      meta_mem[meta_widx] <= meta_wdata;
    end
    meta_rd_q <= meta_mem[found_idx_q];
  end

  always_ff @(posedge clk_i) begin
    if (fail_we) begin
      fail_mem[fail_waddr] <= now_q;
    end
    fail_rd_q <= fail_mem[fail_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      scan_q      <= '0;
      cmp_v_q     <= 1'b0;
      cmp_idx_q   <= '0;
      found_v_q   <= 1'b0;
      found_idx_q <= '0;
      free_v_q    <= 1'b0;
      free_idx_q  <= '0;
      cnt_q       <= '0;
      head_q      <= '0;
      addr_q      <= '0;
      code_q      <= '0;
      now_q       <= '0;
      status_q    <= ST_OK;
      valid_q     <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (req.valid) begin
            if (req.func == FUNC_CLEAR) begin
              valid_q  <= '0;
              status_q <= ST_OK;
              state_q  <= S_DONE;
            end else begin
              addr_q    <= req.client_addr;
              code_q    <= req.submitted_code;
              now_q     <= req.now_seconds;
              scan_q    <= '0;
              cmp_v_q   <= 1'b0;
              found_v_q <= 1'b0;
              free_v_q  <= 1'b0;
              state_q   <= S_SEARCH;
            end
          end
        end
        S_SEARCH: begin
          // one slot read issued and one compared per cycle
          if (cmp_v_q) begin
            if (valid_q[cmp_idx_q] && (addr_rd_q == addr_q) && !found_v_q) begin
              found_v_q   <= 1'b1;
              found_idx_q <= cmp_idx_q;
            end
            if (!valid_q[cmp_idx_q] && !free_v_q) begin
              free_v_q   <= 1'b1;
              free_idx_q <= cmp_idx_q;
            end
          end
          cmp_v_q   <= (scan_q != SW'(CLIENTS));
          cmp_idx_q <= scan_idx;
          if (scan_q != SW'(CLIENTS)) begin
            scan_q <= scan_q + 1'b1;
          end else if (!cmp_v_q) begin
            state_q <= found_v_q ? S_META : S_DECIDE;
          end
        end
        S_META: begin
          state_q <= S_LOAD;
        end
        S_LOAD: begin
          cnt_q   <= meta_rd_q[MW-1:HW];
          head_q  <= meta_rd_q[HW-1:0];
          state_q <= S_PRUNE_RD;
        end
        S_PRUNE_RD: begin
          if (cnt_q == '0) begin
            // ring emptied: slot goes free and competes for lowest free index
            valid_q[found_idx_q] <= 1'b0;
            found_v_q            <= 1'b0;
            if (!free_v_q || (found_idx_q < free_idx_q)) begin
              free_v_q   <= 1'b1;
              free_idx_q <= found_idx_q;
            end
            state_q <= S_DECIDE;
          end else begin
            state_q <= S_PRUNE_CHK;
          end
        end
        S_PRUNE_CHK: begin
          if (expired) begin
            head_q  <= head_inc;
            cnt_q   <= cnt_q - 1'b1;
            state_q <= S_PRUNE_RD;
          end else begin
            state_q <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          status_q <= decide_status;
          if (!limited && pin_ok && found_v_q) begin
            valid_q[found_idx_q] <= 1'b0;
          end
          if (addr_we) begin
            valid_q[free_idx_q] <= 1'b1;
          end
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (res_ready_i) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign req.ready    = (state_q == S_IDLE);
  assign res_o.valid  = (state_q == S_DONE);
  assign res_o.status = status_q;

endmodule
